[rtl/eps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package eps_pkg;

   localparam int unsigned MaxSamplesDefault = 16;

   localparam int unsigned KindWidth        = 2;
   localparam int unsigned CountWidth       = 16;
   localparam int unsigned TickWidth        = 48;
   localparam int unsigned ScaleWidth       = 32;
   localparam int unsigned OutWidth         = 64;
   localparam int unsigned SampleCountWidth = 5;
   localparam int unsigned CsrIndexWidth    = 3;

   localparam logic [ScaleWidth-1:0] TicksPerUnitReset  = 32'd65536;
   localparam logic [ScaleWidth-1:0] PositionScaleReset = 32'd65536;
   localparam logic [ScaleWidth-1:0] SpeedScaleReset    = 32'd65536;
   localparam logic [SampleCountWidth-1:0] SampleCountReset = 5'd1;

   typedef enum logic [KindWidth-1:0] {
      KIND_READ = 2'd0,
      KIND_TICK = 2'd1,
      KIND_SET  = 2'd2
   } kind_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TICKS_PER_UNIT = 3'd0,
      CSR_POSITION_SCALE = 3'd1,
      CSR_SPEED_SCALE    = 3'd2,
      CSR_SAMPLE_COUNT   = 3'd3,
      CSR_SPEED_ENABLE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [KindWidth-1:0]         kind;
      logic signed [CountWidth-1:0] count_delta;
      logic [TickWidth-1:0]         set_ticks;
   } track_item_type;

endpackage

`default_nettype wire

[rtl/eps_set_scaler.sv]
`timescale 1ns / 1ps
`default_nettype none

module eps_set_scaler (
   input  logic                                      clock,
   input  logic                                      load_first,
   input  logic                                      load_second,
   input  logic [eps_pkg::KindWidth-1:0]             kind,
   input  logic signed [eps_pkg::CountWidth-1:0]     count_delta,
   input  logic signed [eps_pkg::TickWidth-1:0]      new_position,
   input  logic [eps_pkg::ScaleWidth-1:0]            ticks_per_unit,
   output eps_pkg::track_item_type                   item
);

   localparam int unsigned TW = eps_pkg::TickWidth;
   localparam int unsigned SW = eps_pkg::ScaleWidth;
   localparam logic [TW:0] NegLimit = (TW+1)'(1) << (TW - 1);
   localparam logic [TW:0] PosLimit = NegLimit - (TW+1)'(1);

   logic [eps_pkg::KindWidth-1:0]         kind_ff;
   logic signed [eps_pkg::CountWidth-1:0] count_ff;
   logic                                  neg_ff;
   logic [TW-1:0]                         pp_hi_ff;
   logic [SW-1:0]                         pp_lo_ff;

   logic [eps_pkg::KindWidth-1:0]         kind2_ff;
   logic signed [eps_pkg::CountWidth-1:0] count2_ff;
   logic [TW-1:0]                         set_ticks_ff;

   logic [TW-1:0]   mag;
   logic [TW-1:0]   pp_hi_in;
   logic [2*SW-1:0] lo_full;
   logic [SW-1:0]   pp_lo_in;
   logic [TW:0]     quot;
   logic [TW:0]     quot_sat;
   logic [TW-1:0]   set_ticks_in;

   always_comb begin
      mag = new_position[TW-1] ? (TW'(0) - new_position) : new_position;
      pp_hi_in = TW'(mag[TW-1:SW]) * TW'(ticks_per_unit);
      lo_full = (2*SW)'(mag[SW-1:0]) * (2*SW)'(ticks_per_unit);
      pp_lo_in = lo_full[2*SW-1:SW];
   end

   // combine partial products, truncate toward zero, clamp to the tick range
   always_comb begin
      quot = (TW+1)'(pp_hi_ff) + (TW+1)'(pp_lo_ff);
      if (neg_ff) begin
         quot_sat = (quot > NegLimit) ? NegLimit : quot;
         set_ticks_in = TW'((TW+1)'(0) - quot_sat);
      end else begin
         quot_sat = (quot > PosLimit) ? PosLimit : quot;
         set_ticks_in = quot_sat[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_first) begin
         kind_ff  <= kind;
         count_ff <= count_delta;
         neg_ff   <= new_position[TW-1];
         pp_hi_ff <= pp_hi_in;
         pp_lo_ff <= pp_lo_in;
      end
      if (load_second) begin
         kind2_ff     <= kind_ff;
         count2_ff    <= count_ff;
         set_ticks_ff <= set_ticks_in;
      end
   end

   assign item.kind        = kind2_ff;
   assign item.count_delta = count2_ff;
   assign item.set_ticks   = set_ticks_ff;

endmodule

`default_nettype wire

[rtl/eps_tracker_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module eps_tracker_core #(
   parameter int unsigned MAX_SAMPLES = eps_pkg::MaxSamplesDefault
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    load,
   input  eps_pkg::track_item_type                                 item,
   input  logic [eps_pkg::SampleCountWidth-1:0]                    sample_count,
   input  logic                                                    window_clear,
   output logic signed [eps_pkg::TickWidth-1:0]                    tick_total,
   output logic signed [eps_pkg::TickWidth+$clog2(MAX_SAMPLES):0]  window_sum
);

   localparam int unsigned TW        = eps_pkg::TickWidth;
   localparam int unsigned SumWidth  = TW + $clog2(MAX_SAMPLES) + 1;
   localparam int unsigned SlotWidth = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int unsigned SlotCount = SlotWidth + 1;

   logic signed [TW-1:0]       tick_total_ff;
   logic signed [TW-1:0]       previous_total_ff;
   logic signed [TW-1:0]       ring_ff [MAX_SAMPLES];
   logic [SlotWidth-1:0]       write_slot_ff;
   logic signed [SumWidth-1:0] window_sum_ff;

   logic signed [TW-1:0]       added;
   logic signed [TW-1:0]       diff;
   logic signed [TW-1:0]       replaced;
   logic signed [SumWidth-1:0] sum_in;
   logic [SlotCount-1:0]       slot_inc;
   logic                       slot_wrap;
   logic [SlotWidth-1:0]       slot_in;

   always_comb begin
      added     = tick_total_ff + TW'(item.count_delta);
      diff      = added - previous_total_ff;
      replaced  = ring_ff[write_slot_ff];
      sum_in    = window_sum_ff + SumWidth'(diff) - SumWidth'(replaced);
      slot_inc  = SlotCount'(write_slot_ff) + SlotCount'(1);
      slot_wrap = (int'(slot_inc) >= int'(sample_count)) || (int'(slot_inc) >= MAX_SAMPLES);
      slot_in   = slot_wrap ? '0 : slot_inc[SlotWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_total_ff     <= '0;
         previous_total_ff <= '0;
         ring_ff           <= '{default: '0};
         write_slot_ff     <= '0;
         window_sum_ff     <= '0;
      end else if (window_clear) begin
         ring_ff       <= '{default: '0};
         write_slot_ff <= '0;
         window_sum_ff <= '0;
      end else if (load) begin
         case (item.kind)
            eps_pkg::KIND_READ: begin
               tick_total_ff <= added;
            end
            eps_pkg::KIND_TICK: begin
               tick_total_ff          <= added;
               previous_total_ff      <= added;
               ring_ff[write_slot_ff] <= diff;
               write_slot_ff          <= slot_in;
               window_sum_ff          <= sum_in;
            end
            eps_pkg::KIND_SET: begin
               tick_total_ff <= item.set_ticks;
            end
            default: begin
            end
         endcase
      end
   end

   assign tick_total = tick_total_ff;
   assign window_sum = window_sum_ff;

   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      int'(write_slot_ff) < int'(sample_count))
      else $error("write slot outside the sample window");

   a_prev_follows_tick: assert property (@(posedge clock) disable iff (reset)
      load && !window_clear && item.kind == eps_pkg::KIND_TICK
      |=> previous_total_ff == tick_total_ff)
      else $error("previous total not updated on sampling tick");

   a_set_keeps_prev: assert property (@(posedge clock) disable iff (reset)
      load && item.kind == eps_pkg::KIND_SET |=> $stable(previous_total_ff))
      else $error("set item changed previous total");

endmodule

`default_nettype wire

[rtl/eps_sat_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module eps_sat_mul #(
   parameter int unsigned A_WIDTH = eps_pkg::TickWidth
) (
   input  logic                                     clock,
   input  logic                                     load_product,
   input  logic                                     load_result,
   input  logic signed [A_WIDTH-1:0]                multiplicand,
   input  logic [eps_pkg::ScaleWidth-1:0]           multiplier,
   output logic signed [eps_pkg::OutWidth-1:0]      result
);

   localparam int unsigned SW        = eps_pkg::ScaleWidth;
   localparam int unsigned OW        = eps_pkg::OutWidth;
   localparam int unsigned HiWidth   = A_WIDTH - SW;
   localparam int unsigned PpWidth   = HiWidth + SW + 1;
   localparam int unsigned FullWidth = A_WIDTH + SW + 1;
   localparam logic [OW-1:0] SatPos  = {1'b0, {(OW-1){1'b1}}};
   localparam logic [OW-1:0] SatNeg  = {1'b1, {(OW-1){1'b0}}};

   logic [2*SW-1:0]              pp_lo_ff;
   logic signed [HiWidth+SW:0]   pp_hi_ff;
   logic signed [OW-1:0]         result_ff;

   logic [2*SW-1:0]              pp_lo_in;
   logic signed [HiWidth+SW:0]   pp_hi_in;
   logic [FullWidth-1:0]         full;
   logic [FullWidth-OW:0]        top_bits;
   logic [OW-1:0]                result_in;

   always_comb begin
      pp_lo_in = (2*SW)'(multiplicand[SW-1:0]) * (2*SW)'(multiplier);
      pp_hi_in = PpWidth'($signed(multiplicand[A_WIDTH-1:SW]))
               * PpWidth'($signed({1'b0, multiplier}));
   end

   // reassemble and clamp to the signed 64-bit range
   always_comb begin
      full      = (FullWidth'(pp_hi_ff) << SW) + FullWidth'(pp_lo_ff);
      top_bits  = full[FullWidth-1:OW-1];
      if ((&top_bits) || !(|top_bits)) begin
         result_in = full[OW-1:0];
      end else begin
         result_in = full[FullWidth-1] ? SatNeg : SatPos;
      end
   end

   always_ff @(posedge clock) begin
      if (load_product) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
      end
      if (load_result) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[rtl/encoder_position_speed_tracker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// 5 register stages take one item per cycle while rsp_tready does not stall the output;
// stages 1-2 scale the set position, stage 3 updates the tick total and delta window,
// stages 4-5 form and clamp the two output products
// a stalled result holds stage by stage; bubbles still let new items in
// reset (synchronous, active high) empties the pipeline, zeroes totals, ring and sum,
// and returns the configuration registers to their defaults

module encoder_position_speed_tracker_unit #(
   parameter int unsigned MAX_SAMPLES = eps_pkg::MaxSamplesDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [63:0]                           req_tdata,   // count_delta, new_position
   input  logic [eps_pkg::KindWidth-1:0]         req_tuser,   // kind
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [127:0]                          rsp_tdata,   // position, speed
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [eps_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [eps_pkg::ScaleWidth-1:0]        csr_data
);

   localparam int unsigned TW       = eps_pkg::TickWidth;
   localparam int unsigned CW       = eps_pkg::CountWidth;
   localparam int unsigned OW       = eps_pkg::OutWidth;
   localparam int unsigned SCW      = eps_pkg::SampleCountWidth;
   localparam int unsigned SumWidth = TW + $clog2(MAX_SAMPLES) + 1;

   logic [eps_pkg::ScaleWidth-1:0] ticks_per_unit_ff;
   logic [eps_pkg::ScaleWidth-1:0] position_scale_ff;
   logic [eps_pkg::ScaleWidth-1:0] speed_scale_ff;
   logic [SCW-1:0]                 sample_count_ff;
   logic                           speed_enable_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, v4_in, rsp_valid_in;
   logic adv2, adv3, adv4, adv5;
   logic req_accept;
   logic csr_write;
   logic window_clear;
   logic [SCW-1:0] sample_count_value;

   eps_pkg::track_item_type      item;
   logic signed [TW-1:0]         tick_total;
   logic signed [SumWidth-1:0]   window_sum;
   logic signed [SumWidth-1:0]   speed_operand;
   logic signed [OW-1:0]         position;
   logic signed [OW-1:0]         speed;

   // pipeline flow
   always_comb begin
      adv5       = v4_ff && (!rsp_valid_ff || rsp_tready);
      adv4       = v3_ff && (!v4_ff || adv5);
      adv3       = v2_ff && (!v3_ff || adv4);
      adv2       = v1_ff && (!v2_ff || adv3);
      req_tready = !v1_ff || adv2;
      req_accept = req_tvalid && req_tready;

      v1_in        = req_accept ? 1'b1 : (adv2 ? 1'b0 : v1_ff);
      v2_in        = adv2 ? 1'b1 : (adv3 ? 1'b0 : v2_ff);
      v3_in        = adv3 ? 1'b1 : (adv4 ? 1'b0 : v3_ff);
      v4_in        = adv4 ? 1'b1 : (adv5 ? 1'b0 : v4_ff);
      rsp_valid_in = adv5 ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   assign csr_ready    = 1'b1;
   assign csr_write    = csr_valid && csr_ready;
   assign window_clear = csr_write && (csr_index == eps_pkg::CSR_SAMPLE_COUNT);

   always_comb begin
      sample_count_value = csr_data[SCW-1:0];
      if (sample_count_value == '0) begin
         sample_count_value = SCW'(1);
      end else if (int'(sample_count_value) > MAX_SAMPLES) begin
         sample_count_value = SCW'(MAX_SAMPLES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_unit_ff <= eps_pkg::TicksPerUnitReset;
         position_scale_ff <= eps_pkg::PositionScaleReset;
         speed_scale_ff    <= eps_pkg::SpeedScaleReset;
         sample_count_ff   <= eps_pkg::SampleCountReset;
         speed_enable_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            eps_pkg::CSR_TICKS_PER_UNIT: begin
               ticks_per_unit_ff <= (csr_data == '0) ? eps_pkg::ScaleWidth'(1) : csr_data;
            end
            eps_pkg::CSR_POSITION_SCALE: begin
               position_scale_ff <= csr_data;
            end
            eps_pkg::CSR_SPEED_SCALE: begin
               speed_scale_ff <= csr_data;
            end
            eps_pkg::CSR_SAMPLE_COUNT: begin
               sample_count_ff <= sample_count_value;
            end
            eps_pkg::CSR_SPEED_ENABLE: begin
               speed_enable_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   eps_set_scaler u_set_scaler (
      .clock          (clock),
      .load_first     (req_accept),
      .load_second    (adv2),
      .kind           (req_tuser),
      .count_delta    (req_tdata[CW-1:0]),
      .new_position   (req_tdata[CW+TW-1:CW]),
      .ticks_per_unit (ticks_per_unit_ff),
      .item           (item)
   );

   eps_tracker_core #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_tracker_core (
      .clock        (clock),
      .reset        (reset),
      .load         (adv3),
      .item         (item),
      .sample_count (sample_count_ff),
      .window_clear (window_clear),
      .tick_total   (tick_total),
      .window_sum   (window_sum)
   );

   assign speed_operand = speed_enable_ff ? window_sum : '0;

   eps_sat_mul #(
      .A_WIDTH (TW)
   ) u_position_mul (
      .clock        (clock),
      .load_product (adv4),
      .load_result  (adv5),
      .multiplicand (tick_total),
      .multiplier   (position_scale_ff),
      .result       (position)
   );

   eps_sat_mul #(
      .A_WIDTH (SumWidth)
   ) u_speed_mul (
      .clock        (clock),
      .load_product (adv4),
      .load_result  (adv5),
      .multiplicand (speed_operand),
      .multiplier   (speed_scale_ff),
      .result       (speed)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {speed, position};

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled with a free pipeline stage");

endmodule

`default_nettype wire

[verif/tb_encoder_position_speed_tracker_unit.sv]
`timescale 1ns / 1ps

module tb_encoder_position_speed_tracker_unit;
   import eps_pkg::*;

   localparam int unsigned MaxSamples = MaxSamplesDefault;
   localparam logic [KindWidth-1:0] KindUnused = 2'd3;
   localparam logic [CsrIndexWidth-1:0] CsrUnused = 3'd5;
   localparam int unsigned CycleLimit = 400000;
   localparam logic [47:0] TargetMax = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] TargetMin = 48'h8000_0000_0000;
   localparam logic [15:0] CountMax = 16'h7FFF;
   localparam logic [15:0] CountMin = 16'h8000;

   typedef struct {
      logic signed [63:0] position;
      logic signed [63:0] speed;
   } motion_type;

   class motion_tracker;
      logic [31:0]        ticks_per_unit;
      logic [31:0]        position_scale;
      logic [31:0]        speed_scale;
      int unsigned        window_len;
      bit                 speed_on;
      logic signed [47:0] tick_total;
      logic signed [47:0] prior_total;
      logic signed [47:0] delta_ring [MaxSamples];
      int unsigned        ring_slot;
      logic signed [52:0] window_sum;
      motion_type         expected_motion [$];
      int unsigned        errors;

      function new();
         ticks_per_unit = TicksPerUnitReset;
         position_scale = PositionScaleReset;
         speed_scale = SpeedScaleReset;
         window_len = SampleCountReset;
         speed_on = 1'b0;
         tick_total = '0;
         prior_total = '0;
         errors = 0;
         clear_window();
      endfunction

      function void clear_window();
         foreach (delta_ring[i]) delta_ring[i] = '0;
         ring_slot = 0;
         window_sum = '0;
      endfunction

      task report_mismatch(input string what);
         errors++;
         $display("mismatch: %s", what);
      endtask

      function logic signed [63:0] clamp_product(input logic signed [63:0] a,
                                                 input logic [31:0] b);
         logic signed [96:0] full;
         full = a * $signed({1'b0, b});
         if (full[96:63] != {34{full[63]}})
            return full[96] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
         return full[63:0];
      endfunction

      function logic [47:0] ticks_from_target(input logic [47:0] target);
         logic [47:0] mag;
         logic [79:0] prod;
         logic [47:0] q;
         mag = target[47] ? (48'd0 - target) : target;
         prod = mag * ticks_per_unit;
         q = prod[79:32];
         if (target[47]) begin
            if (q > 48'h8000_0000_0000) q = 48'h8000_0000_0000;
            return 48'd0 - q;
         end
         if (q > 48'h7FFF_FFFF_FFFF) q = 48'h7FFF_FFFF_FFFF;
         return q;
      endfunction

      function void set_register(input logic [CsrIndexWidth-1:0] idx, input logic [31:0] value);
         case (idx)
            CSR_TICKS_PER_UNIT: ticks_per_unit = (value == 0) ? 32'd1 : value;
            CSR_POSITION_SCALE: position_scale = value;
            CSR_SPEED_SCALE:    speed_scale = value;
            CSR_SAMPLE_COUNT: begin
               window_len = value[4:0];
               if (window_len == 0) window_len = 1;
               if (window_len > MaxSamples) window_len = MaxSamples;
               clear_window();
            end
            CSR_SPEED_ENABLE:   speed_on = value[0];
            default: ;
         endcase
      endfunction

      function void absorb_item(input logic [KindWidth-1:0] kind, input logic signed [15:0] count,
                                input logic [47:0] target);
         logic signed [47:0] change;
         motion_type m;
         if (kind == KIND_READ || kind == KIND_TICK) tick_total = tick_total + count;
         if (kind == KIND_TICK) begin
            change = tick_total - prior_total;
            window_sum = window_sum + change - delta_ring[ring_slot];
            delta_ring[ring_slot] = change;
            ring_slot++;
            if (ring_slot >= window_len) ring_slot = 0;
            prior_total = tick_total;
         end else if (kind == KIND_SET) begin
            tick_total = ticks_from_target(target);
         end
         m.position = clamp_product(tick_total, position_scale);
         m.speed = speed_on ? clamp_product(window_sum, speed_scale) : 64'sd0;
         expected_motion.push_back(m);
      endfunction

      task compare_motion(input logic [127:0] data);
         motion_type m;
         if (expected_motion.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, data %h", data));
            return;
         end
         m = expected_motion.pop_front();
         if (data[63:0] !== m.position)
            report_mismatch($sformatf("position %h, wanted %h", data[63:0], m.position));
         if (data[127:64] !== m.speed)
            report_mismatch($sformatf("speed %h, wanted %h", data[127:64], m.speed));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [63:0]              req_tdata;
   logic [KindWidth-1:0]     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [127:0]             rsp_tdata;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [ScaleWidth-1:0]    csr_data;

   motion_tracker tracker = new();
   int unsigned   send_idle_pct;
   int unsigned   recv_stall_pct;
   int unsigned   cycles;

   encoder_position_speed_tracker_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(negedge clock) rsp_tready = ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.compare_motion(rsp_tdata);
   end

   task automatic send_item(input logic [KindWidth-1:0] kind, input logic [15:0] count,
                            input logic [47:0] target);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {target, count};
      do @(posedge clock); while (!req_tready);
      tracker.absorb_item(kind, count, target);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid = 1'b0;
      while (tracker.expected_motion.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] idx, input logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all(input logic [31:0] tpu, input logic [31:0] pscale,
                            input logic [31:0] sscale, input logic [31:0] count,
                            input logic [31:0] enable);
      settle();
      write_register(CSR_TICKS_PER_UNIT, tpu);
      write_register(CSR_POSITION_SCALE, pscale);
      write_register(CSR_SPEED_SCALE, sscale);
      write_register(CSR_SAMPLE_COUNT, count);
      write_register(CSR_SPEED_ENABLE, enable);
   endtask

   function automatic logic [31:0] pick_scale();
      return $urandom_range(1) ? $urandom : $urandom_range(1, 1 << 18);
   endfunction

   task automatic random_items(input int unsigned n);
      int unsigned r;
      logic [KindWidth-1:0] kind;
      logic [15:0] count;
      logic [47:0] target;
      logic [23:0] near;
      for (int unsigned i = 0; i < n; i++) begin
         r = $urandom_range(99);
         kind = (r < 45) ? KIND_READ : (r < 85) ? KIND_TICK : (r < 95) ? KIND_SET : KindUnused;
         case ($urandom_range(3))
            0: count = 16'($urandom_range(64)) - 16'd32;
            1: count = $urandom_range(1) ? CountMax : CountMin;
            default: count = 16'($urandom);
         endcase
         near = 24'($urandom);
         target = $urandom_range(1) ? {16'($urandom), 32'($urandom)} : {{24{near[23]}}, near};
         send_item(kind, count, target);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_READ;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_TICKS_PER_UNIT;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // defaults first, then a mid-range window with speed on
      send_item(KIND_READ, 16'd100, 48'd0);
      send_item(KIND_TICK, 16'd50, 48'd0);
      write_all(32'h0001_8000, 32'h0000_AAAB, 32'h0001_0000, 32'd4, 32'd1);
      write_register(CsrUnused, 32'hFFFF_FFFF);
      send_item(KIND_READ, CountMax, 48'd0);
      send_item(KIND_READ, CountMin, 48'd0);
      send_item(KIND_READ, 16'd0, TargetMax);
      send_item(KIND_TICK, 16'd5, 48'd0);
      send_item(KIND_TICK, 16'hFFFD, TargetMin);
      send_item(KIND_TICK, CountMax, 48'd0);
      send_item(KIND_TICK, CountMin, 48'd0);
      send_item(KIND_TICK, 16'd0, 48'd0);
      send_item(KIND_SET, 16'd1234, TargetMax);
      send_item(KIND_READ, CountMax, 48'd0);
      send_item(KIND_TICK, 16'd0, 48'd0);
      send_item(KIND_SET, CountMax, TargetMin);
      send_item(KIND_READ, CountMin, 48'd0);
      send_item(KIND_TICK, 16'd7, 48'd0);
      send_item(KIND_SET, 16'd0, 48'd0);
      send_item(KindUnused, 16'd100, 48'd12345);
      send_item(KIND_READ, 16'hFFFF, 48'd0);
      send_item(KIND_TICK, 16'd1, 48'd0);
      send_item(KindUnused, CountMin, TargetMax);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd31, 32'd1);
            1: write_all(32'd0, 32'd1, 32'd0, 32'd0, 32'd1);
            2: write_all(pick_scale(), pick_scale(), pick_scale(), 32'd16, 32'd1);
            3: write_all(pick_scale(), pick_scale(), 32'd0, 32'd1, 32'd0);
            default: write_all($urandom, pick_scale(), pick_scale(),
                               $urandom_range(31), $urandom_range(1));
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         random_items(240);
      end

      settle();
      repeat (20) @(posedge clock);
      if (tracker.expected_motion.size() != 0)
         tracker.report_mismatch("results still pending at end");
      if (tracker.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
